@@ sv/psho_pkg.sv @@
`default_nettype none
package psho_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CoordW  = 24;
  localparam int unsigned RadiusW = 16;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned BoxW    = 23;
  localparam int unsigned InvW    = 32;
  localparam int unsigned CountW  = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_BOX_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BOX_INV    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ATOM_COUNT = 2'd2;

  // Operation codes carried in the input tuser.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Axis codes.
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr;
    logic       rd_i;
    logic       rd_j;
    logic       load_i;
    logic       load_j;
    logic       mul_en;
    logic       wrap_en;
    logic       sq_en;
    logic       acc_en;
    logic       acc_clr;
    logic [1:0] axis;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic flag_i;
    logic flag_j;
    logic hit;
  } status_t;

endpackage
`default_nettype wire

@@ sv/psho_ram.sv @@
`default_nettype none
module psho_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ sv/psho_datapath.sv @@
`default_nettype none
module psho_datapath
  import psho_pkg::*;
#(
  parameter int unsigned MAX_ATOMS           = 1024,
  parameter int unsigned COORD_FRACTION_BITS = 8
) (
  input  wire logic                         clk_i,
  input  wire cmd_t                         cmd_i,
  output status_t                           status_o,
  input  wire logic [$clog2(MAX_ATOMS)-1:0] waddr_i,
  input  wire logic [$clog2(MAX_ATOMS)-1:0] raddr_i_i,
  input  wire logic [$clog2(MAX_ATOMS)-1:0] raddr_j_i,
  input  wire logic [3*CoordW-1:0]          current_i,
  input  wire logic [3*CoordW-1:0]          trial_i,
  input  wire logic [RadiusW-1:0]           rad_i,
  input  wire logic                         moved_i,
  input  wire logic [BoxW-1:0]              box_length_i,
  input  wire logic [InvW-1:0]              box_inv_i
);

  localparam int unsigned RecW  = 3 * CoordW + RadiusW + 1;
  localparam int unsigned DW    = CoordW + 1;
  localparam int unsigned PW    = DW + InvW;
  localparam int unsigned Shift = InvW + COORD_FRACTION_BITS;
  localparam int unsigned NW    = PW + 1 - Shift;
  localparam int unsigned NLW   = NW + BoxW;
  localparam int unsigned WW    = NLW + 2;
  localparam int unsigned AW    = 31;
  localparam int unsigned SqW   = 2 * AW;
  localparam int unsigned AccW  = SqW + 2;
  localparam int unsigned RsW   = RadiusW + 1;

  logic [RecW-1:0] cand_rd, pres_rd;
  logic [RecW-1:0] rec_i_q, rec_j_q;

  // Candidate store is read at the moved atom, present store at the other.
  psho_ram #(.WIDTH(RecW), .DEPTH(MAX_ATOMS)) u_cand_ram (
    .clk_i, .we_i(cmd_i.wr), .waddr_i,
    .wdata_i({moved_i, rad_i, trial_i}),
    .re_i(cmd_i.rd_i), .raddr_i(raddr_i_i), .rdata_o(cand_rd)
  );

  psho_ram #(.WIDTH(RecW), .DEPTH(MAX_ATOMS)) u_pres_ram (
    .clk_i, .we_i(cmd_i.wr), .waddr_i,
    .wdata_i({moved_i, rad_i, current_i}),
    .re_i(cmd_i.rd_j), .raddr_i(raddr_j_i), .rdata_o(pres_rd)
  );

  // Record registers for the pair under test.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_i) begin
      rec_i_q <= cand_rd;
    end
    if (cmd_i.load_j) begin
      rec_j_q <= pres_rd;
    end
  end

  // Axis select and raw difference.
  logic signed [CoordW-1:0] ci, pj;
  logic signed [DW-1:0]     d;
  logic        [DW-1:0]     mag;

  always_comb begin
    case (cmd_i.axis)
      AX_X: begin
        ci = rec_i_q[CoordW-1:0];
        pj = rec_j_q[CoordW-1:0];
      end
      AX_Y: begin
        ci = rec_i_q[2*CoordW-1:CoordW];
        pj = rec_j_q[2*CoordW-1:CoordW];
      end
      default: begin
        ci = rec_i_q[3*CoordW-1:2*CoordW];
        pj = rec_j_q[3*CoordW-1:2*CoordW];
      end
    endcase
    d   = DW'(pj) - DW'(ci);
    mag = d[DW-1] ? DW'(-d) : d;
  end

  logic signed [DW-1:0]  d_q;
  logic                  neg_q;
  logic        [PW-1:0]  p_q;
  logic        [2*RsW-1:0] rsq_q;
  logic        [RsW-1:0] rsum;

  assign rsum = RsW'(rec_i_q[3*CoordW +: RadiusW]) + RsW'(rec_j_q[3*CoordW +: RadiusW]);

  // Scale by the reciprocal box edge and square the radius sum.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      d_q   <= d;
      neg_q <= d[DW-1];
      p_q   <= PW'(mag) * PW'(box_inv_i);
      rsq_q <= (2*RsW)'(rsum) * (2*RsW)'(rsum);
    end
  end

  // Round half away from zero, then scale the wrap count by the box edge.
  logic [PW:0]    p_rnd;
  logic [NW-1:0]  n_mag;
  logic [NLW-1:0] nl_q;

  assign p_rnd = {1'b0, p_q} + ((PW+1)'(1) << (Shift - 1));
  assign n_mag = p_rnd[PW:Shift];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wrap_en) begin
      nl_q <= NLW'(n_mag) * NLW'(box_length_i);
    end
  end

  // Wrapped component, saturated, then squared.
  logic signed [WW-1:0] w, lim;
  logic        [AW-1:0] a;
  logic        [SqW-1:0] sq_q;

  always_comb begin
    lim = WW'(32'h7FFF_FFFF);
    w   = neg_q ? (WW'(d_q) + $signed(WW'(nl_q))) : (WW'(d_q) - $signed(WW'(nl_q)));
    if (w > lim) begin
      a = AW'(lim);
    end else if (w < -lim) begin
      a = AW'(lim);
    end else if (w < 0) begin
      a = AW'(-w);
    end else begin
      a = AW'(w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sq_q <= SqW'(a) * SqW'(a);
    end
  end

  // Squared distance accumulator.
  logic [AccW-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + AccW'(sq_q);
    end
  end

  assign status_o.flag_i = cand_rd[RecW-1];
  assign status_o.flag_j = pres_rd[RecW-1];
  assign status_o.hit    = acc_q < AccW'(rsq_q);

endmodule
`default_nettype wire

@@ sv/psho_ctrl.sv @@
`default_nettype none
module psho_ctrl
  import psho_pkg::*;
#(
  parameter int unsigned MAX_ATOMS = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         in_op_i,
  input  wire logic [IndexW-1:0]            in_index_i,
  input  wire logic [CountW-1:0]            atom_count_i,
  output cmd_t                              cmd_o,
  input  wire status_t                      status_i,
  output logic [$clog2(MAX_ATOMS)-1:0]      waddr_o,
  output logic [$clog2(MAX_ATOMS)-1:0]      raddr_i_o,
  output logic [$clog2(MAX_ATOMS)-1:0]      raddr_j_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              out_found_o,
  output logic [IndexW-1:0]                 out_moved_o,
  output logic [IndexW-1:0]                 out_other_o
);

  localparam int unsigned CW = $clog2(MAX_ATOMS + 1);
  localparam int unsigned AW = $clog2(MAX_ATOMS);
  localparam int unsigned KW = (CW > CountW ? CW : CountW) + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD_I = 4'd1;
  localparam logic [3:0] S_WT_I = 4'd2;
  localparam logic [3:0] S_RD_J = 4'd3;
  localparam logic [3:0] S_WT_J = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_WRAP = 4'd6;
  localparam logic [3:0] S_SQ   = 4'd7;
  localparam logic [3:0] S_ACC  = 4'd8;
  localparam logic [3:0] S_CMP  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, cnt;
  logic [1:0]    axis_q, axis_d;
  logic          found_q, found_d;
  logic          ov_q, ov_d, of_q, of_d;
  logic [IndexW-1:0] om_q, om_d, oo_q, oo_d;
  logic          accept;

  // Effective atom count, clamped to the store depth.
  assign cnt = (KW'(atom_count_i) > KW'(MAX_ATOMS)) ? CW'(MAX_ATOMS) : CW'(atom_count_i);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign waddr_o    = AW'(in_index_i);
  assign raddr_i_o  = i_q[AW-1:0];
  assign raddr_j_o  = j_q[AW-1:0];

  // Pair walk sequencer.
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    axis_d  = axis_q;
    found_d = found_q;
    ov_d    = ov_q;
    of_d    = of_q;
    om_d    = om_q;
    oo_d    = oo_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_LOAD) begin
            cmd_o.wr = KW'(in_index_i) < KW'(MAX_ATOMS);
          end else begin
            i_d     = '0;
            found_d = 1'b0;
            state_d = (cnt == '0) ? S_DONE : S_RD_I;
          end
        end
      end
      S_RD_I: begin
        cmd_o.rd_i = 1'b1;
        state_d    = S_WT_I;
      end
      S_WT_I: begin
        cmd_o.load_i = 1'b1;
        if (status_i.flag_i) begin
          j_d     = '0;
          state_d = S_RD_J;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = (i_q + 1'b1 == cnt) ? S_DONE : S_RD_I;
        end
      end
      S_RD_J: begin
        cmd_o.rd_j = 1'b1;
        state_d    = S_WT_J;
      end
      S_WT_J: begin
        cmd_o.load_j  = 1'b1;
        cmd_o.acc_clr = 1'b1;
        axis_d        = AX_X;
        if (status_i.flag_j) begin
          if (j_q + 1'b1 == cnt) begin
            i_d     = i_q + 1'b1;
            state_d = (i_q + 1'b1 == cnt) ? S_DONE : S_RD_I;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_RD_J;
          end
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_WRAP;
      end
      S_WRAP: begin
        cmd_o.wrap_en = 1'b1;
        state_d       = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq_en = 1'b1;
        state_d     = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (axis_q == AX_Z) begin
          state_d = S_CMP;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_CMP: begin
        if (status_i.hit) begin
          found_d = 1'b1;
          state_d = S_DONE;
        end else if (j_q + 1'b1 == cnt) begin
          i_d     = i_q + 1'b1;
          state_d = (i_q + 1'b1 == cnt) ? S_DONE : S_RD_I;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_RD_J;
        end
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          of_d    = found_q;
          om_d    = found_q ? IndexW'(i_q) : '0;
          oo_d    = found_q ? IndexW'(j_q) : '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      found_q <= found_d;
    end
  end

  // Counters and result payload.
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    axis_q <= axis_d;
    of_q   <= of_d;
    om_q   <= om_d;
    oo_q   <= oo_d;
  end

  assign out_valid_o = ov_q;
  assign out_found_o = of_q;
  assign out_moved_o = om_q;
  assign out_other_o = oo_q;

endmodule
`default_nettype wire

@@ sv/periodic_hard_sphere_overlap.sv @@
`default_nettype none
// Hard-sphere overlap checker with periodic minimum-image wrapping. A load word (tuser 0)
// writes one atom record. A check word (tuser 1) walks every moved/unmoved pair in
// ascending order and returns one result word with the first overlapping pair. Each
// atom slot is read from the store, and so is every inner slot visited for a moved atom,
// moved or not; each tested pair passes through the shared multiply, wrap, square and
// accumulate unit, one axis after another, and a check stops early when it hits.
// Stores hold no valid bits; only loaded slots may be checked.
module periodic_hard_sphere_overlap
  import psho_pkg::*;
#(
  parameter int unsigned MAX_ATOMS           = 1024,
  parameter int unsigned COORD_FRACTION_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // atom_index, current_x, current_y, current_z, trial_x, trial_y, trial_z,
  // sphere_radius, in_moved_group, zero fill
  input  wire logic [175:0]       s_axis_tdata,
  // opcode
  input  wire logic [0:0]         s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // overlap_found, first_moved_atom, first_other_atom, zero fill
  output logic [23:0]             m_axis_tdata,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_ATOMS);

  logic [BoxW-1:0]   box_q;
  logic [InvW-1:0]   inv_q;
  logic [CountW-1:0] count_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q   <= BoxW'(38400);
      inv_q   <= InvW'(28633115);
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BOX_LENGTH: box_q   <= cfg_data_i[BoxW-1:0];
        REG_BOX_INV:    inv_q   <= cfg_data_i[InvW-1:0];
        REG_ATOM_COUNT: count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  cmd_t    cmd;
  status_t status;
  logic [AW-1:0] waddr, raddr_i, raddr_j;
  logic          found;
  logic [IndexW-1:0] moved_idx, other_idx;

  psho_ctrl #(.MAX_ATOMS(MAX_ATOMS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_op_i(s_axis_tuser[0]), .in_index_i(s_axis_tdata[IndexW-1:0]),
    .atom_count_i(count_q),
    .cmd_o(cmd), .status_i(status),
    .waddr_o(waddr), .raddr_i_o(raddr_i), .raddr_j_o(raddr_j),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_found_o(found), .out_moved_o(moved_idx), .out_other_o(other_idx)
  );

  psho_datapath #(
    .MAX_ATOMS(MAX_ATOMS), .COORD_FRACTION_BITS(COORD_FRACTION_BITS)
  ) u_dp (
    .clk_i, .cmd_i(cmd), .status_o(status),
    .waddr_i(waddr), .raddr_i_i(raddr_i), .raddr_j_i(raddr_j),
    .current_i(s_axis_tdata[81:10]), .trial_i(s_axis_tdata[153:82]),
    .rad_i(s_axis_tdata[169:154]), .moved_i(s_axis_tdata[170]),
    .box_length_i(box_q), .box_inv_i(inv_q)
  );

  assign m_axis_tdata = {3'b000, other_idx, moved_idx, found};

endmodule
`default_nettype wire

@@ sv/psho_checker.sv @@
`default_nettype none
module psho_checker
  import psho_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [0:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  // A pending result word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // A check word occupies the block: no word is taken in the next cycle.
  a_check_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_CHECK) |=> !s_axis_tready)
    else $error("input taken right after a check word");

  // A load word keeps the block ready for the next word.
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_LOAD) |=> s_axis_tready)
    else $error("load word stalled the input");

  // A result without overlap carries zero atom indexes.
  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[20:1] == 20'd0))
    else $error("nonzero atom indexes without an overlap");

endmodule

bind periodic_hard_sphere_overlap psho_checker u_psho_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tuser(s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
